// ===== sv/mbet_pkg.sv =====
// mbet_pkg: shared types, constants and saturating fixed-point helpers
// for the mandelbrot escape-time block. No dependencies.
package mbet_pkg;

  localparam int WORD_WIDTH = 32;
  localparam int FRAC_BITS  = 28;
  localparam int PROD_W     = 2 * WORD_WIDTH;
  localparam int CNT_W      = 16;

  typedef logic signed [WORD_WIDTH-1:0] word_t;
  typedef logic signed [PROD_W-1:0]     prod_t;
  typedef logic [CNT_W-1:0]             cnt_t;

  localparam word_t WORD_MAX = {1'b0, {(WORD_WIDTH-1){1'b1}}};
  localparam word_t WORD_MIN = {1'b1, {(WORD_WIDTH-1){1'b0}}};
  localparam word_t FOUR     = (FRAC_BITS + 3 >= WORD_WIDTH) ? WORD_MAX :
                               word_t'(word_t'(4) <<< FRAC_BITS);

  localparam cnt_t MAX_ITER_RESET = cnt_t'(1000);

  typedef struct packed {
    logic load;
    logic mul;
    logic upd;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic limit_zero;
    logic escape;
    logic last;
  } dp_sts_t;

  function automatic word_t sat_add(word_t a, word_t b);
    logic signed [WORD_WIDTH:0] s;
    s = {a[WORD_WIDTH-1], a} + {b[WORD_WIDTH-1], b};
    if (s[WORD_WIDTH] != s[WORD_WIDTH-1]) begin
      return s[WORD_WIDTH] ? WORD_MIN : WORD_MAX;
    end
    return s[WORD_WIDTH-1:0];
  endfunction

  function automatic word_t sat_sub(word_t a, word_t b);
    logic signed [WORD_WIDTH:0] s;
    s = {a[WORD_WIDTH-1], a} - {b[WORD_WIDTH-1], b};
    if (s[WORD_WIDTH] != s[WORD_WIDTH-1]) begin
      return s[WORD_WIDTH] ? WORD_MIN : WORD_MAX;
    end
    return s[WORD_WIDTH-1:0];
  endfunction

  // floor(p / 2^s) saturated to the word range
  function automatic word_t sat_prod(prod_t p, int unsigned s);
    prod_t q;
    logic  all_ones;
    logic  all_zeros;
    q         = p >>> s;
    all_ones  = &q[PROD_W-1:WORD_WIDTH-1];
    all_zeros = ~(|q[PROD_W-1:WORD_WIDTH-1]);
    if (all_ones || all_zeros) begin
      return q[WORD_WIDTH-1:0];
    end
    return q[PROD_W-1] ? WORD_MIN : WORD_MAX;
  endfunction

endpackage

// ===== sv/mbet_datapath.sv =====
// mbet_datapath: z registers, product registers, iteration counter,
// limit register and result register. Uses mbet_pkg.
module mbet_datapath (
  input  logic                      clk,
  input  logic                      rst_n,
  input  mbet_pkg::dp_cmd_t         cmd,
  output mbet_pkg::dp_sts_t         sts,
  input  logic                      cfg_we,
  input  mbet_pkg::cnt_t            cfg_max_iterations,
  input  mbet_pkg::word_t           in_c_real,
  input  mbet_pkg::word_t           in_c_imag,
  output mbet_pkg::cnt_t            out_iteration_count,
  output logic                      out_escaped
);

  mbet_pkg::word_t cr_r, ci_r, x_r, y_r;
  mbet_pkg::word_t x_nxt, y_nxt;
  mbet_pkg::prod_t pxx_r, pyy_r, pxy_r;
  mbet_pkg::cnt_t  cnt_r, cnt_nxt, max_r;
  mbet_pkg::cnt_t  out_cnt_r;
  logic            esc_r, esc_nxt, out_esc_r;

  mbet_pkg::word_t xx, yy, xy2, mag;
  logic [mbet_pkg::CNT_W:0] cnt_inc;

  always_comb begin
    xx      = mbet_pkg::sat_prod(pxx_r, mbet_pkg::FRAC_BITS);
    yy      = mbet_pkg::sat_prod(pyy_r, mbet_pkg::FRAC_BITS);
    xy2     = mbet_pkg::sat_prod(pxy_r, mbet_pkg::FRAC_BITS - 1);
    mag     = mbet_pkg::sat_add(xx, yy);
    cnt_inc = {1'b0, cnt_r} + {{mbet_pkg::CNT_W{1'b0}}, 1'b1};

    sts.limit_zero = (max_r == '0);
    sts.escape     = (mag > mbet_pkg::FOUR);
    sts.last       = (cnt_inc == {1'b0, max_r});

    x_nxt   = x_r;
    y_nxt   = y_r;
    cnt_nxt = cnt_r;
    esc_nxt = esc_r;
    if (cmd.load) begin
      x_nxt   = '0;
      y_nxt   = '0;
      cnt_nxt = '0;
      esc_nxt = 1'b0;
    end else if (cmd.upd) begin
      if (sts.escape) begin
        esc_nxt = 1'b1;
      end else begin
        x_nxt   = mbet_pkg::sat_add(mbet_pkg::sat_sub(xx, yy), cr_r);
        y_nxt   = mbet_pkg::sat_add(xy2, ci_r);
        cnt_nxt = cnt_inc[mbet_pkg::CNT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r <= mbet_pkg::MAX_ITER_RESET;
    end else if (cfg_we) begin
      max_r <= cfg_max_iterations;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cr_r <= in_c_real;
      ci_r <= in_c_imag;
    end
    if (cmd.mul) begin
      pxx_r <= mbet_pkg::prod_t'(x_r) * mbet_pkg::prod_t'(x_r);
      pyy_r <= mbet_pkg::prod_t'(y_r) * mbet_pkg::prod_t'(y_r);
      pxy_r <= mbet_pkg::prod_t'(x_r) * mbet_pkg::prod_t'(y_r);
    end
    if (cmd.out_load) begin
      out_cnt_r <= cnt_r;
      out_esc_r <= esc_r;
    end
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    cnt_r <= cnt_nxt;
    esc_r <= esc_nxt;
  end

  assign out_iteration_count = out_cnt_r;
  assign out_escaped         = out_esc_r;

endmodule

// ===== sv/mbet_ctrl.sv =====
// mbet_ctrl: iteration sequencer and output valid register.
// Drives datapath commands from its status. Uses mbet_pkg.
module mbet_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output mbet_pkg::dp_cmd_t cmd,
  input  mbet_pkg::dp_sts_t sts
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_MUL,
    S_UPD,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  always_comb begin
    out_free = !out_valid_r || !out_stall;

    cmd.load     = (state_r == S_IDLE) && in_valid;
    cmd.mul      = (state_r == S_MUL);
    cmd.upd      = (state_r == S_UPD);
    cmd.out_load = (state_r == S_DONE) && out_free;

    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = sts.limit_zero ? S_DONE : S_MUL;
        end
      end
      S_MUL: begin
        state_nxt = S_UPD;
      end
      S_UPD: begin
        if (sts.escape || sts.last) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_MUL;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

// ===== sv/mandelbrot_escape_time.sv =====
// mandelbrot_escape_time: one point at a time; each iteration is a multiply
// state (S_MUL), then a saturate-and-update state (S_UPD). After accept these
// alternate until escape or the limit ends the run (a zero limit goes straight
// to S_DONE); S_DONE loads the result and raises out_valid when output is free.
// Synchronous active-low reset: idle, no result pending, limit back to 1000.
// Depends on mbet_pkg, mbet_ctrl and mbet_datapath.
module mandelbrot_escape_time (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  mbet_pkg::word_t        in_c_real,
  input  mbet_pkg::word_t        in_c_imag,
  output logic                   out_valid,
  input  logic                   out_stall,
  output mbet_pkg::cnt_t         out_iteration_count,
  output logic                   out_escaped,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  mbet_pkg::cnt_t         cfg_max_iterations
);

  mbet_pkg::dp_cmd_t cmd;
  mbet_pkg::dp_sts_t sts;

  assign cfg_ready = 1'b1;

  mbet_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  mbet_datapath u_datapath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .cfg_we              (cfg_valid && cfg_ready),
    .cfg_max_iterations  (cfg_max_iterations),
    .in_c_real           (in_c_real),
    .in_c_imag           (in_c_imag),
    .out_iteration_count (out_iteration_count),
    .out_escaped         (out_escaped)
  );

endmodule
